/* design/tsf_pkg.sv */
// tsf_pkg: shared types, codes and constants of the touch sample filter
// used by the front end, the item queue, the back end and the top level
`default_nettype none

package tsf_pkg;

	localparam int WORD_W    = 16;
	localparam int RAW_W     = 13;
	localparam int DELTA_W   = RAW_W + 1;
	localparam int GAIN_W    = 16;
	localparam int TICK_W    = 8;
	localparam int POS_W     = 20;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	localparam int TSF_QUEUE_DEPTH = 2;

	localparam logic [RAW_W-1:0] Z_LIMIT    = RAW_W'(4000);
	localparam logic [RAW_W:0]   Z_FULL     = (RAW_W+1)'(4095);
	localparam int               POS_OFFSET = 25;
	localparam int               GAIN_SHIFT = 9;

	localparam logic [RAW_W-1:0]  RST_X_ORIGIN     = '0;
	localparam logic [RAW_W-1:0]  RST_Y_ORIGIN     = '0;
	localparam logic [GAIN_W-1:0] RST_X_GAIN       = GAIN_W'(512);
	localparam logic [GAIN_W-1:0] RST_Y_GAIN       = GAIN_W'(512);
	localparam logic [RAW_W-1:0]  RST_PRESSURE_MIN = RAW_W'(400);
	localparam logic [TICK_W-1:0] RST_CAPTURE      = TICK_W'(10);
	localparam logic [TICK_W-1:0] RST_HOLDOFF      = TICK_W'(5);

	localparam logic OP_PEN  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic KIND_PRESS = 1'b0;
	localparam logic KIND_REARM = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_ORIGIN     = 3'd0,
		CFG_Y_ORIGIN     = 3'd1,
		CFG_X_GAIN       = 3'd2,
		CFG_Y_GAIN       = 3'd3,
		CFG_PRESSURE_MIN = 3'd4,
		CFG_CAPTURE      = 3'd5,
		CFG_HOLDOFF      = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_CAPT = 3'b010,
		MODE_HOLD = 3'b100
	} mode_t;

	// classified frame as it travels from front to back
	typedef struct packed {
		logic                      op;
		logic                      pvalid;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
	} tsf_item_t;

endpackage

`default_nettype wire

/* design/tsf_front.sv */
// tsf_front: pressure check and middle-two mean of each axis for one beat
// depends on tsf_pkg; feeds tsf_queue
`default_nettype none

module tsf_front (
	input  wire logic                       op,
	input  wire logic [tsf_pkg::WORD_W-1:0] z1_word,
	input  wire logic [tsf_pkg::WORD_W-1:0] z2_word,
	input  wire logic [tsf_pkg::WORD_W-1:0] a_word0,
	input  wire logic [tsf_pkg::WORD_W-1:0] a_word1,
	input  wire logic [tsf_pkg::WORD_W-1:0] a_word2,
	input  wire logic [tsf_pkg::WORD_W-1:0] a_word3,
	input  wire logic [tsf_pkg::WORD_W-1:0] b_word0,
	input  wire logic [tsf_pkg::WORD_W-1:0] b_word1,
	input  wire logic [tsf_pkg::WORD_W-1:0] b_word2,
	input  wire logic [tsf_pkg::WORD_W-1:0] b_word3,
	input  wire logic [tsf_pkg::RAW_W-1:0]  x_origin,
	input  wire logic [tsf_pkg::RAW_W-1:0]  y_origin,
	input  wire logic [tsf_pkg::RAW_W-1:0]  pressure_min,
	output tsf_pkg::tsf_item_t              item
);
	import tsf_pkg::*;

	function automatic logic [RAW_W-1:0] mid_mean(
		input logic [RAW_W-1:0] r0,
		input logic [RAW_W-1:0] r1,
		input logic [RAW_W-1:0] r2,
		input logic [RAW_W-1:0] r3
	);
		logic [RAW_W+1:0] sum;
		logic [RAW_W-1:0] lo01, lo23, hi01, hi23, lo, hi;
		logic [RAW_W+1:0] mid;
		sum  = (RAW_W+2)'(r0) + (RAW_W+2)'(r1) + (RAW_W+2)'(r2) + (RAW_W+2)'(r3);
		lo01 = (r0 < r1) ? r0 : r1;
		hi01 = (r0 < r1) ? r1 : r0;
		lo23 = (r2 < r3) ? r2 : r3;
		hi23 = (r2 < r3) ? r3 : r2;
		lo   = (lo01 < lo23) ? lo01 : lo23;
		hi   = (hi01 < hi23) ? hi23 : hi01;
		mid  = sum - (RAW_W+2)'(lo) - (RAW_W+2)'(hi);
		return mid[RAW_W:1];
	endfunction

	logic [RAW_W-1:0] z1, z2, rx, ry;
	logic [RAW_W:0]   zsum;

	assign z1   = z1_word[WORD_W-1:3];
	assign z2   = z2_word[WORD_W-1:3];
	// both readings within limit keeps the sum positive, so no clamp is needed
	assign zsum = {1'b0, z1} + Z_FULL - {1'b0, z2};

	assign ry = mid_mean(a_word0[WORD_W-1:3], a_word1[WORD_W-1:3],
		a_word2[WORD_W-1:3], a_word3[WORD_W-1:3]);
	assign rx = mid_mean(b_word0[WORD_W-1:3], b_word1[WORD_W-1:3],
		b_word2[WORD_W-1:3], b_word3[WORD_W-1:3]);

	always_comb begin
		item.op     = op;
		item.pvalid = (z1 <= Z_LIMIT) && (z2 <= Z_LIMIT) && (zsum >= {1'b0, pressure_min});
		item.dx     = $signed({1'b0, rx}) - $signed({1'b0, x_origin});
		item.dy     = $signed({1'b0, ry}) - $signed({1'b0, y_origin});
	end

endmodule

`default_nettype wire

/* design/tsf_queue.sv */
// tsf_queue: short first-in first-out queue of classified beats
// depends on tsf_pkg; sits between tsf_front and tsf_back
`default_nettype none

module tsf_queue #(
	parameter int DEPTH = tsf_pkg::TSF_QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output logic                    push_ready,
	input  wire tsf_pkg::tsf_item_t push_item,
	output logic                    pop_valid,
	input  wire logic               pop_ready,
	output tsf_pkg::tsf_item_t      pop_item
);
	import tsf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tsf_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_fire, pop_fire;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_fire, pop_fire})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push_fire && !pop_fire |=> count_q == $past(count_q) + 1'b1)
		else $error("push without pop did not grow the queue");

endmodule

`default_nettype wire

/* design/tsf_back.sv */
// tsf_back: press state machine, coordinate scaling and result register
// depends on tsf_pkg; takes beats from tsf_queue
`default_nettype none

module tsf_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_ready,
	input  wire tsf_pkg::tsf_item_t         item,
	input  wire logic [tsf_pkg::GAIN_W-1:0] x_gain,
	input  wire logic [tsf_pkg::GAIN_W-1:0] y_gain,
	input  wire logic [tsf_pkg::TICK_W-1:0] capture_ticks,
	input  wire logic [tsf_pkg::TICK_W-1:0] holdoff_ticks,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            kind,
	output logic [tsf_pkg::POS_W-1:0]       x_pos,
	output logic [tsf_pkg::POS_W-1:0]       y_pos
);
	import tsf_pkg::*;

	localparam int PROD_W  = DELTA_W + GAIN_W + 1;
	localparam int QUOT_W  = PROD_W - GAIN_SHIFT;
	localparam int SCALE_W = QUOT_W + 1;

	mode_t               mode_q, mode_d;
	logic [TICK_W-1:0]   cnt_q, cnt_d, cnt_inc;
	logic                take;
	logic                res_v, res_kind;
	logic [POS_W-1:0]    res_x, res_y;
	logic signed [PROD_W-1:0]  px, py;
	logic [SCALE_W-1:0]  sx, sy;
	logic                out_valid_q, kind_q;
	logic [POS_W-1:0]    x_pos_q, y_pos_q;

	assign item_ready = !out_valid_q || out_ready;
	assign take       = item_valid && item_ready;

	// floor shift by the gain point, then the screen offset
	assign px = item.dx * $signed({1'b0, x_gain});
	assign py = item.dy * $signed({1'b0, y_gain});
	assign sx = {px[PROD_W-1], px[PROD_W-1:GAIN_SHIFT]} + SCALE_W'(POS_OFFSET);
	assign sy = {py[PROD_W-1], py[PROD_W-1:GAIN_SHIFT]} + SCALE_W'(POS_OFFSET);

	assign cnt_inc = (cnt_q == {TICK_W{1'b1}}) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		mode_d   = mode_q;
		cnt_d    = cnt_q;
		res_v    = 1'b0;
		res_kind = KIND_REARM;
		res_x    = '0;
		res_y    = '0;
		unique case (mode_q)
			MODE_CAPT: begin
				if (item.op == OP_TICK) begin
					if (!item.pvalid) begin
						mode_d = MODE_IDLE;
						res_v  = 1'b1;
					end else begin
						cnt_d = cnt_inc;
						if (cnt_inc > capture_ticks && !sx[SCALE_W-1] && !sy[SCALE_W-1]) begin
							mode_d   = MODE_HOLD;
							cnt_d    = holdoff_ticks;
							res_v    = 1'b1;
							res_kind = KIND_PRESS;
							res_x    = sx[POS_W-1:0];
							res_y    = sy[POS_W-1:0];
						end
					end
				end
			end
			MODE_HOLD: begin
				if (item.op == OP_TICK) begin
					if (cnt_q <= TICK_W'(1)) begin
						cnt_d  = '0;
						mode_d = MODE_IDLE;
						res_v  = 1'b1;
					end else begin
						cnt_d = cnt_q - 1'b1;
					end
				end
			end
			default: begin
				if (item.op == OP_PEN) begin
					mode_d = MODE_CAPT;
					cnt_d  = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				mode_q <= mode_d;
				cnt_q  <= cnt_d;
			end
			if (take && res_v) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_v) begin
			kind_q  <= res_kind;
			x_pos_q <= res_x;
			y_pos_q <= res_y;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign x_pos     = x_pos_q;
	assign y_pos     = y_pos_q;

	a_press_holds: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_v && res_kind == KIND_PRESS |=>
		mode_q == MODE_HOLD && cnt_q == $past(holdoff_ticks))
		else $error("press report did not enter holdoff");

	a_rearm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_REARM |-> x_pos_q == '0 && y_pos_q == '0)
		else $error("re-arm beat carries coordinates");

	a_holdoff_count: assert property (@(posedge clk) disable iff (!arst_n)
		take && mode_q == MODE_HOLD && item.op == OP_TICK && cnt_q > TICK_W'(1) |=>
		cnt_q == $past(cnt_q) - 1'b1 && mode_q == MODE_HOLD)
		else $error("holdoff countdown slipped");

endmodule

`default_nettype wire

/* design/touch_sample_filter_and_press_fsm.sv */
// Touch sample filter and press detector, one item per clock cycle. A beat is taken whenever
// the two-entry queue between the front end and the back end has room; the front end checks
// pressure and averages the middle two readings of each axis in the cycle of acceptance, the
// back end runs the press state machine and the two coordinate multipliers one queued beat a
// cycle while its output register is free or being drained. A result is registered once the back
// end takes its beat from the queue; the gain multiply and offset add set the longest path.
// Configuration is a plain write port, to be used only while no beat is in flight.
// depends on tsf_pkg, tsf_front, tsf_queue, tsf_back
`default_nettype none

module touch_sample_filter_and_press_fsm #(
	parameter int QUEUE_DEPTH = tsf_pkg::TSF_QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          op,
	input  wire logic [tsf_pkg::WORD_W-1:0]    z1_word,
	input  wire logic [tsf_pkg::WORD_W-1:0]    z2_word,
	input  wire logic [tsf_pkg::WORD_W-1:0]    a_word0,
	input  wire logic [tsf_pkg::WORD_W-1:0]    a_word1,
	input  wire logic [tsf_pkg::WORD_W-1:0]    a_word2,
	input  wire logic [tsf_pkg::WORD_W-1:0]    a_word3,
	input  wire logic [tsf_pkg::WORD_W-1:0]    b_word0,
	input  wire logic [tsf_pkg::WORD_W-1:0]    b_word1,
	input  wire logic [tsf_pkg::WORD_W-1:0]    b_word2,
	input  wire logic [tsf_pkg::WORD_W-1:0]    b_word3,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               kind,
	output logic [tsf_pkg::POS_W-1:0]          x_pos,
	output logic [tsf_pkg::POS_W-1:0]          y_pos,
	input  wire logic                          cfg_we,
	input  wire logic [tsf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [tsf_pkg::CFG_W-1:0]     cfg_data
);
	import tsf_pkg::*;

	logic [RAW_W-1:0]  x_origin_q, y_origin_q, pressure_min_q;
	logic [GAIN_W-1:0] x_gain_q, y_gain_q;
	logic [TICK_W-1:0] capture_q, holdoff_q;
	tsf_item_t         front_item, back_item;
	logic              back_valid, back_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q     <= RST_X_ORIGIN;
			y_origin_q     <= RST_Y_ORIGIN;
			x_gain_q       <= RST_X_GAIN;
			y_gain_q       <= RST_Y_GAIN;
			pressure_min_q <= RST_PRESSURE_MIN;
			capture_q      <= RST_CAPTURE;
			holdoff_q      <= RST_HOLDOFF;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_X_ORIGIN:     x_origin_q     <= cfg_data[RAW_W-1:0];
				CFG_Y_ORIGIN:     y_origin_q     <= cfg_data[RAW_W-1:0];
				CFG_X_GAIN:       x_gain_q       <= cfg_data[GAIN_W-1:0];
				CFG_Y_GAIN:       y_gain_q       <= cfg_data[GAIN_W-1:0];
				CFG_PRESSURE_MIN: pressure_min_q <= cfg_data[RAW_W-1:0];
				CFG_CAPTURE:      capture_q      <= cfg_data[TICK_W-1:0];
				CFG_HOLDOFF:      holdoff_q      <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	tsf_front u_front (
		.op           (op),
		.z1_word      (z1_word),
		.z2_word      (z2_word),
		.a_word0      (a_word0),
		.a_word1      (a_word1),
		.a_word2      (a_word2),
		.a_word3      (a_word3),
		.b_word0      (b_word0),
		.b_word1      (b_word1),
		.b_word2      (b_word2),
		.b_word3      (b_word3),
		.x_origin     (x_origin_q),
		.y_origin     (y_origin_q),
		.pressure_min (pressure_min_q),
		.item         (front_item)
	);

	tsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	tsf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (back_valid),
		.item_ready    (back_ready),
		.item          (back_item),
		.x_gain        (x_gain_q),
		.y_gain        (y_gain_q),
		.capture_ticks (capture_q),
		.holdoff_ticks (holdoff_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.x_pos         (x_pos),
		.y_pos         (y_pos)
	);

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for touch_sample_filter_and_press_fsm: directed frame table, then randomised phases
// checked against a press-state predictor under several register settings and idle patterns
// depends on tsf_pkg and the touch_sample_filter_and_press_fsm top level
`timescale 1ns / 100ps

module testbench;
	import tsf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 8;
	localparam int IDLE_PCT    = 69;
	localparam int BOTH_PCT    = 8;
	localparam int ZMAX        = int'(Z_LIMIT);
	localparam int ZSPAN       = int'(Z_FULL);
	localparam int RAW_MAX     = 8191;

	typedef struct packed {
		logic                        op;
		logic [WORD_W-1:0]           z1;
		logic [WORD_W-1:0]           z2;
		logic [3:0][WORD_W-1:0]      a;
		logic [3:0][WORD_W-1:0]      b;
	} frame_t;

	typedef struct packed {
		logic             kind;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} press_t;

	typedef enum {BY_MODEL, NO_RESULT, REARM, PRESS} row_check_t;

	typedef struct {
		frame_t           f;
		row_check_t       chk;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic op;
	logic [WORD_W-1:0] z1_word, z2_word;
	logic [WORD_W-1:0] a_word0, a_word1, a_word2, a_word3;
	logic [WORD_W-1:0] b_word0, b_word1, b_word2, b_word3;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind;
	logic [POS_W-1:0] x_pos, y_pos;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	// predictor state and register copies
	mode_t             st;
	logic [TICK_W-1:0] tick_cnt;
	logic [RAW_W-1:0]  x_org, y_org, p_min;
	logic [GAIN_W-1:0] x_gn, y_gn;
	logic [TICK_W-1:0] capt_n, hold_n;

	press_t   press_q[$];
	dir_row_t dir_rows[$];
	int       failures = 0;
	int       cycle_count = 0;
	int       send_idle_pct = 0;
	int       stall_pct = 0;

	touch_sample_filter_and_press_fsm dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.z1_word(z1_word),
		.z2_word(z2_word),
		.a_word0(a_word0),
		.a_word1(a_word1),
		.a_word2(a_word2),
		.a_word3(a_word3),
		.b_word0(b_word0),
		.b_word1(b_word1),
		.b_word2(b_word2),
		.b_word3(b_word3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.x_pos(x_pos),
		.y_pos(y_pos),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin : result_check
		press_t want;
		if (arst_n && out_valid && out_ready) begin
			if (press_q.size() == 0) begin
				$error("unexpected beat: kind %0d x_pos %0d y_pos %0d", kind, x_pos, y_pos);
				failures++;
			end else begin
				want = press_q.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					failures++;
				end
				if (x_pos !== want.x) begin
					$error("x_pos: expected %0d, got %0d", want.x, x_pos);
					failures++;
				end
				if (y_pos !== want.y) begin
					$error("y_pos: expected %0d, got %0d", want.y, y_pos);
					failures++;
				end
			end
		end
	end

	function automatic int middle_mean(input logic [3:0][WORD_W-1:0] w);
		int lo, hi, sum, v;
		lo = 'hF000;
		hi = 0;
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			v = int'(w[i][WORD_W-1:3]);
			sum += v;
			if (v < lo) lo = v;
			if (v > hi) hi = v;
		end
		return (sum - lo - hi) / 2;
	endfunction

	function automatic longint screen_pos(input int raw, input logic [RAW_W-1:0] org,
			input logic [GAIN_W-1:0] gn);
		longint p;
		p = longint'(raw - int'(org)) * longint'(gn);
		return POS_OFFSET + (p >>> GAIN_SHIFT);
	endfunction

	// one accepted beat through the press state machine
	function automatic bit predict_press(input frame_t f, output press_t r);
		int z1, z2, z, rx, ry;
		longint sx, sy;
		r = '0;
		if (st != MODE_CAPT && st != MODE_HOLD) begin
			if (f.op == OP_PEN) begin
				st = MODE_CAPT;
				tick_cnt = '0;
			end
			return 0;
		end
		if (f.op == OP_PEN)
			return 0;
		if (st == MODE_HOLD) begin
			if (tick_cnt <= 1) begin
				tick_cnt = '0;
				st = MODE_IDLE;
				r.kind = KIND_REARM;
				return 1;
			end
			tick_cnt--;
			return 0;
		end
		z1 = int'(f.z1[WORD_W-1:3]);
		z2 = int'(f.z2[WORD_W-1:3]);
		z = z1 + ZSPAN - z2;
		if (z < 0) z = 0;
		if (z1 > ZMAX || z2 > ZMAX || z < int'(p_min)) begin
			st = MODE_IDLE;
			r.kind = KIND_REARM;
			return 1;
		end
		ry = middle_mean(f.a);
		rx = middle_mean(f.b);
		if (tick_cnt < 255) tick_cnt++;
		if (tick_cnt <= capt_n)
			return 0;
		sx = screen_pos(rx, x_org, x_gn);
		sy = screen_pos(ry, y_org, y_gn);
		if (sx < 0 || sy < 0)
			return 0;
		st = MODE_HOLD;
		tick_cnt = hold_n;
		r.kind = KIND_PRESS;
		r.x = sx[POS_W-1:0];
		r.y = sy[POS_W-1:0];
		return 1;
	endfunction

	function automatic logic [WORD_W-1:0] word_of(input int reading);
		return {reading[RAW_W-1:0], 3'($urandom)};
	endfunction

	function automatic logic [3:0][WORD_W-1:0] axis_words();
		logic [3:0][WORD_W-1:0] w;
		int pick;
		pick = $urandom_range(9);
		for (int i = 0; i < 4; i++)
			w[i] = WORD_W'($urandom);
		if (pick == 0)
			w = {4{w[0]}};
		else if (pick == 1)
			for (int i = 0; i < 4; i++)
				w[i] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		return w;
	endfunction

	task automatic add_row(input logic o, input logic [WORD_W-1:0] z1, z2,
			input logic [63:0] a, b, input row_check_t chk,
			input logic [POS_W-1:0] x, y);
		dir_row_t r;
		r.f.op = o;
		r.f.z1 = z1;
		r.f.z2 = z2;
		r.f.a = a;
		r.f.b = b;
		r.chk = chk;
		r.x = x;
		r.y = y;
		dir_rows.push_back(r);
	endtask

	task automatic feed(input frame_t f, input row_check_t chk,
			input logic [POS_W-1:0] xe, ye);
		press_t got;
		bit has;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= f.op;
		z1_word <= f.z1;
		z2_word <= f.z2;
		a_word0 <= f.a[0];
		a_word1 <= f.a[1];
		a_word2 <= f.a[2];
		a_word3 <= f.a[3];
		b_word0 <= f.b[0];
		b_word1 <= f.b[1];
		b_word2 <= f.b[2];
		b_word3 <= f.b[3];
		do @(posedge clk); while (!in_ready);
		has = predict_press(f, got);
		if (chk == REARM)
			got = '{kind: KIND_REARM, x: '0, y: '0};
		else if (chk == PRESS)
			got = '{kind: KIND_PRESS, x: xe, y: ye};
		if (chk == REARM || chk == PRESS || (chk == BY_MODEL && has))
			press_q.push_back(got);
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (press_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			CFG_X_ORIGIN:     x_org = val[RAW_W-1:0];
			CFG_Y_ORIGIN:     y_org = val[RAW_W-1:0];
			CFG_X_GAIN:       x_gn = val[GAIN_W-1:0];
			CFG_Y_GAIN:       y_gn = val[GAIN_W-1:0];
			CFG_PRESSURE_MIN: p_min = val[RAW_W-1:0];
			CFG_CAPTURE:      capt_n = val[TICK_W-1:0];
			CFG_HOLDOFF:      hold_n = val[TICK_W-1:0];
			default: ;
		endcase
	endtask

	task automatic run_phase(input int xo, yo, xg, yg, pm, cn, hn,
			input int idle_in, idle_out, bad_pct, n);
		frame_t f;
		int roll, z1r, z2r, zlo, zhi, counted;
		bit busy;
		drain_pipeline();
		write_reg(CFG_X_ORIGIN, CFG_W'(xo));
		write_reg(CFG_Y_ORIGIN, CFG_W'(yo));
		write_reg(CFG_X_GAIN, CFG_W'(xg));
		write_reg(CFG_Y_GAIN, CFG_W'(yg));
		write_reg(CFG_PRESSURE_MIN, CFG_W'(pm));
		write_reg(CFG_CAPTURE, CFG_W'(cn));
		write_reg(CFG_HOLDOFF, CFG_W'(hn));
		@(negedge clk);
		cfg_we <= 1'b0;
		send_idle_pct = idle_in;
		stall_pct = idle_out;
		counted = 0;
		while (counted < n) begin
			f.op = OP_TICK;
			f.z1 = WORD_W'($urandom);
			f.z2 = WORD_W'($urandom);
			f.a = axis_words();
			f.b = axis_words();
			busy = (st == MODE_CAPT || st == MODE_HOLD);
			if (st == MODE_CAPT) begin
				roll = $urandom_range(99);
				if (roll < 4) begin
					f.op = OP_PEN;
				end else if (roll < 4 + bad_pct) begin
					case ($urandom_range(2))
						0: f.z1 = word_of($urandom_range(RAW_MAX, ZMAX + 1));
						1: f.z2 = word_of($urandom_range(RAW_MAX, ZMAX + 1));
						default: begin
							// pressure below the minimum with both readings in range
							if (pm >= ZSPAN + 1 - ZMAX) begin
								zhi = pm - (ZSPAN + 1 - ZMAX);
								z1r = $urandom_range(zhi > ZMAX ? ZMAX : zhi);
								zlo = z1r + ZSPAN + 1 - pm;
								z2r = $urandom_range(ZMAX, zlo < 0 ? 0 : zlo);
								f.z1 = word_of(z1r);
								f.z2 = word_of(z2r);
							end else begin
								f.z1 = word_of($urandom_range(RAW_MAX, ZMAX + 1));
							end
						end
					endcase
				end else begin
					zlo = (pm > ZSPAN) ? pm - ZSPAN : 0;
					if (zlo <= ZMAX) begin
						z1r = $urandom_range(ZMAX, zlo);
						zhi = z1r + ZSPAN - pm;
						z2r = $urandom_range(zhi > ZMAX ? ZMAX : zhi, 0);
						f.z1 = word_of(z1r);
						f.z2 = word_of(z2r);
					end
				end
			end else if (st == MODE_HOLD) begin
				if ($urandom_range(99) < 8) f.op = OP_PEN;
			end else begin
				if ($urandom_range(99) < 85) f.op = OP_PEN;
			end
			if ((f.op == OP_TICK) == busy)
				counted++;
			feed(f, BY_MODEL, '0, '0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_PEN;
		z1_word = '0;
		z2_word = '0;
		a_word0 = '0;
		a_word1 = '0;
		a_word2 = '0;
		a_word3 = '0;
		b_word0 = '0;
		b_word1 = '0;
		b_word2 = '0;
		b_word3 = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		st = MODE_IDLE;
		tick_cnt = '0;
		x_org = RST_X_ORIGIN;
		y_org = RST_Y_ORIGIN;
		x_gn = RST_X_GAIN;
		y_gn = RST_Y_GAIN;
		p_min = RST_PRESSURE_MIN;
		capt_n = RST_CAPTURE;
		hold_n = RST_HOLDOFF;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: capture 10, holdoff 5, unity gain, zero origin
		add_row(OP_TICK, 16'h7D00, 16'h0000, 64'h0, 64'h0, NO_RESULT, 0, 0);
		add_row(OP_PEN, 16'h0000, 16'h0000, 64'h0, 64'h0, BY_MODEL, 0, 0);
		add_row(OP_PEN, 16'hFFFF, 16'hFFFF, '1, '1, NO_RESULT, 0, 0);
		add_row(OP_TICK, 16'h7D08, 16'h0000, 64'h0, 64'h0, REARM, 0, 0);
		add_row(OP_PEN, 16'h0000, 16'h0000, 64'h0, 64'h0, BY_MODEL, 0, 0);
		add_row(OP_TICK, 16'h0000, 16'hFFFF, 64'h0, 64'h0, REARM, 0, 0);
		add_row(OP_PEN, 16'h0000, 16'h0000, 64'h0, 64'h0, BY_MODEL, 0, 0);
		add_row(OP_TICK, 16'h0000, 16'h7D00, 64'h0, 64'h0, REARM, 0, 0);
		add_row(OP_PEN, 16'h0000, 16'h0000, 64'h0, 64'h0, BY_MODEL, 0, 0);
		add_row(OP_TICK, 16'h7D07, 16'h7D07, 64'h0000_FFFF_0000_FFFF,
			64'hFFFF_0000_FFFF_0000, BY_MODEL, 0, 0);
		add_row(OP_TICK, 16'h0000, 16'h7378, 64'h1234_8000_0007_FFF8,
			64'hAAAA_5555_C3C3_3C3C, BY_MODEL, 0, 0);
		add_row(OP_TICK, 16'h7D00, 16'h0000, 64'h0008_0010_0018_0020,
			64'hFFF8_FFF0_FFE8_FFE0, BY_MODEL, 0, 0);
		add_row(OP_TICK, 16'h7D00, 16'h0000, 64'h7FFF_7FFF_7FFF_7FFF,
			64'h8000_8000_8000_8000, BY_MODEL, 0, 0);
		add_row(OP_TICK, 16'h7D00, 16'h0000, 64'h0001_0002_0004_0008,
			64'h1000_2000_4000_8000, BY_MODEL, 0, 0);
		add_row(OP_TICK, 16'h7D00, 16'h0000, 64'h5A5A_A5A5_0F0F_F0F0,
			64'h0123_4567_89AB_CDEF, BY_MODEL, 0, 0);
		add_row(OP_TICK, 16'h7D00, 16'h0000, 64'hFFFF_0000_0000_0000,
			64'h0000_0000_0000_FFFF, BY_MODEL, 0, 0);
		add_row(OP_TICK, 16'h7D00, 16'h0000, 64'hDEAD_BEEF_CAFE_F00D,
			64'h1111_2222_3333_4444, BY_MODEL, 0, 0);
		add_row(OP_TICK, 16'h7D00, 16'h0000, 64'h0000_0000_FFFF_FFFF,
			64'hFFFF_FFFF_0000_0000, BY_MODEL, 0, 0);
		add_row(OP_TICK, 16'h7D00, 16'h0000, 64'h4000_2000_1000_0800,
			64'h0400_0200_0100_0080, BY_MODEL, 0, 0);
		// eleventh good tick reports full-scale x and zero y
		add_row(OP_TICK, 16'h7D00, 16'h0000, 64'h0, '1, PRESS, 20'd8216, 20'd25);
		add_row(OP_PEN, 16'hFFFF, 16'hFFFF, '1, '1, NO_RESULT, 0, 0);
		add_row(OP_TICK, 16'hFFFF, 16'hFFFF, '1, '1, NO_RESULT, 0, 0);
		add_row(OP_TICK, 16'hFFFF, 16'hFFFF, '1, '1, NO_RESULT, 0, 0);
		add_row(OP_TICK, 16'hFFFF, 16'hFFFF, '1, '1, NO_RESULT, 0, 0);
		add_row(OP_TICK, 16'hFFFF, 16'hFFFF, '1, '1, NO_RESULT, 0, 0);
		add_row(OP_TICK, 16'hFFFF, 16'hFFFF, '1, '1, REARM, 0, 0);
		foreach (dir_rows[i])
			feed(dir_rows[i].f, dir_rows[i].chk, dir_rows[i].x, dir_rows[i].y);

		run_phase(0, 0, 512, 512, 400, 10, 5, 0, 0, 8, 60);
		run_phase(0, 0, 65535, 65535, 0, 0, 1, IDLE_PCT, 0, 8, 60);
		run_phase(4096, 100, 1000, 300, 2000, 3, 255, 0, IDLE_PCT, 8, 170);
		// count climbs to 255 before the report
		run_phase(8191, 8191, 0, 0, 4000, 254, 0, BOTH_PCT, BOTH_PCT, 0, 270);
		// large origin, mostly negative coordinates
		run_phase(6000, 2000, 40000, 20000, 95, 1, 0, 0, 0, 10, 70);
		run_phase(200, 0, 512, 65535, 8095, 2, 2, IDLE_PCT, 0, 10, 60);
		run_phase(1000, 1000, 512, 512, 8191, 5, 5, BOTH_PCT, BOTH_PCT, 0, 30);
		run_phase($urandom_range(8191), $urandom_range(8191), $urandom_range(65535),
			$urandom_range(65535), $urandom_range(3000), $urandom_range(8),
			$urandom_range(6, 1), 0, IDLE_PCT, 10, 60);
		// saturating count, never reports
		run_phase(0, 0, 512, 512, 400, 255, 3, 0, 0, 0, 270);
		drain_pipeline();

		if (failures == 0 && press_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
